// ===== rtl/core/cbu_pkg.sv =====
// cbu_pkg: types, codes, constants and the arctangent table of the camera basis update
// used by the top level, controller, datapath and bench; depends on nothing

package cbu_pkg;

	localparam int TRIG_ITERATIONS_DEF = 16;
	localparam int DIR_WIDTH_DEF       = 16;
	localparam int MUL_W               = 34;
	localparam int STEP_W              = 6;
	localparam int SQRT_STEPS          = 32;
	localparam int CORDIC_GAIN_Q30     = 652032874;
	localparam int DEG90_Q8            = 23040;
	localparam int DEG180_Q8           = 46080;
	localparam int POS_Z_RESET         = 20 * 65536;

	localparam logic [2:0] OP_RESET   = 3'd0;
	localparam logic [2:0] OP_MOVE    = 3'd1;
	localparam logic [2:0] OP_ROT_X   = 3'd2;
	localparam logic [2:0] OP_ROT_Y   = 3'd3;
	localparam logic [2:0] OP_ROT_Z   = 3'd4;
	localparam logic [2:0] OP_FORWARD = 3'd5;
	localparam logic [2:0] OP_STRAFE  = 3'd6;
	localparam logic [2:0] OP_UPWARD  = 3'd7;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [15:0] rotate_angle;
		logic signed [31:0] travel_distance;
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic signed [31:0] move_z;
	} cam_cmd_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] view_x;
		logic signed [15:0] view_y;
		logic signed [15:0] view_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
	} cam_res_t;

	typedef enum logic [4:0] {
		UOP_NONE, UOP_LOAD, UOP_RESET, UOP_MOVE, UOP_TRAVEL_MUL, UOP_TRAVEL_ADD,
		UOP_TRIG_INIT, UOP_TRIG_STEP, UOP_MIX_P, UOP_MIX_Q, UOP_MIX_W, UOP_SQ,
		UOP_SQ_ACC, UOP_SQRT_INIT, UOP_SQRT_STEP, UOP_DIV_INIT, UOP_DIV_STEP,
		UOP_DIV_WRITE, UOP_CROSS_A, UOP_CROSS_B, UOP_CROSS_W, UOP_CAPTURE
	} uop_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_TRAVEL_MUL, S_TRAVEL_ADD, S_TRIG_INIT, S_TRIG_STEP,
		S_MIX_P, S_MIX_Q, S_MIX_W, S_SQ, S_SQ_ACC, S_SQRT_INIT, S_SQRT_STEP,
		S_NORM_CHECK, S_DIV_INIT, S_DIV_STEP, S_DIV_WRITE, S_CROSS_A, S_CROSS_B,
		S_CROSS_W, S_FINISH
	} ctl_state_t;

	typedef struct packed {
		uop_t              uop;
		logic [1:0]        k;
		logic [STEP_W-1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       len_zero;
	} dp_stat_t;

	// arctangent of 2^-i in degrees, q24
	function automatic logic signed [39:0] atan_q24(input logic [4:0] idx);
		logic signed [39:0] v;
		case (idx)
			5'd0:  v = 40'sd754974720;
			5'd1:  v = 40'sd445687602;
			5'd2:  v = 40'sd235489088;
			5'd3:  v = 40'sd119537938;
			5'd4:  v = 40'sd60000934;
			5'd5:  v = 40'sd30029717;
			5'd6:  v = 40'sd15018523;
			5'd7:  v = 40'sd7509720;
			5'd8:  v = 40'sd3754917;
			5'd9:  v = 40'sd1877466;
			5'd10: v = 40'sd938734;
			5'd11: v = 40'sd469367;
			5'd12: v = 40'sd234684;
			5'd13: v = 40'sd117342;
			5'd14: v = 40'sd58671;
			5'd15: v = 40'sd29335;
			5'd16: v = 40'sd14668;
			5'd17: v = 40'sd7334;
			5'd18: v = 40'sd3667;
			5'd19: v = 40'sd1833;
			5'd20: v = 40'sd917;
			5'd21: v = 40'sd458;
			5'd22: v = 40'sd229;
			5'd23: v = 40'sd115;
			default: v = 40'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/cbu_stream_if.sv =====
// cbu_stream_if: valid/ready channel carrying one payload beat
// payload type is set by the instantiating level

interface cbu_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/camera_basis_update.sv =====
// camera_basis_update: top level of the free-look camera position and basis unit
// depends on cbu_pkg, cbu_stream_if, cbu_controller and cbu_datapath
//
// usage:
//   cmd carries one command beat (opcode, angle, distance, move vector); res
//   returns one beat per command with the updated position and the view, up
//   and right vectors in q2.14.
//   cmd.ready is high only while the block is idle; one command is worked at
//   a time through one shared multiplier, a cordic, a bit-serial square root
//   and a bit-serial divider.
//   reset and move update the state straight from decode; forward, strafe and
//   upward run a multiply and an add per axis; a rotation runs the cordic, the
//   square root (32 steps) and the three divides (DIR_WIDTH steps each).
//   a rotation whose mixed vector has zero length skips the divides.
//   no new command is taken until the last one has finished and the block is idle again.
//   the result sits in an output register; the next command is accepted while
//   it waits, and a finished command holds until res is free.
//   reset puts the position at (0, 0, 20) and the basis at view (0, 0, -1),
//   up (0, 1, 0), right (1, 0, 0), with no result pending.

module camera_basis_update #(
	parameter int TRIG_ITERATIONS = cbu_pkg::TRIG_ITERATIONS_DEF,
	parameter int DIR_WIDTH       = cbu_pkg::DIR_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cbu_stream_if.sink   cmd,
	cbu_stream_if.source res
);

	cbu_pkg::dp_cmd_t  dp_cmd;
	cbu_pkg::dp_stat_t dp_stat;
	cbu_pkg::cam_cmd_t in_data;
	cbu_pkg::cam_res_t out_data;
	logic              in_ready;
	logic              out_valid;

	assign in_data   = cmd.data;
	assign cmd.ready = in_ready;
	assign res.valid = out_valid;
	assign res.data  = out_data;

	cbu_controller #(
		.TRIG_ITERATIONS(TRIG_ITERATIONS),
		.DIR_WIDTH(DIR_WIDTH)
	) u_ctl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cmd.valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(res.ready),
		.cmd(dp_cmd),
		.stat(dp_stat)
	);

	cbu_datapath #(
		.DIR_WIDTH(DIR_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(dp_cmd),
		.stat(dp_stat),
		.in_data(in_data),
		.out_data(out_data)
	);

endmodule

// ===== rtl/core/cbu_controller.sv =====
// cbu_controller: state machine sequencing the datapath micro operations
// depends on cbu_pkg

module cbu_controller #(
	parameter int TRIG_ITERATIONS = cbu_pkg::TRIG_ITERATIONS_DEF,
	parameter int DIR_WIDTH       = cbu_pkg::DIR_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output cbu_pkg::dp_cmd_t   cmd,
	input  cbu_pkg::dp_stat_t  stat
);

	localparam int SW = cbu_pkg::STEP_W;

	cbu_pkg::ctl_state_t state_q, state_d;
	logic [1:0]    k_q, k_d;
	logic [SW-1:0] i_q, i_d;
	logic          out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbu_pkg::S_IDLE;
			k_q         <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			k_q         <= k_d;
			i_q         <= i_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		i_d         = i_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd.uop     = cbu_pkg::UOP_NONE;
		cmd.k       = k_q;
		cmd.step    = i_q;
		in_ready    = 1'b0;
		unique case (state_q)
			cbu_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.uop = cbu_pkg::UOP_LOAD;
					state_d = cbu_pkg::S_DECODE;
				end
			end
			cbu_pkg::S_DECODE: begin
				k_d = '0;
				i_d = '0;
				case (stat.opcode)
					cbu_pkg::OP_RESET: begin
						cmd.uop = cbu_pkg::UOP_RESET;
						state_d = cbu_pkg::S_FINISH;
					end
					cbu_pkg::OP_MOVE: begin
						cmd.uop = cbu_pkg::UOP_MOVE;
						state_d = cbu_pkg::S_FINISH;
					end
					cbu_pkg::OP_ROT_X, cbu_pkg::OP_ROT_Y, cbu_pkg::OP_ROT_Z: begin
						state_d = cbu_pkg::S_TRIG_INIT;
					end
					default: begin
						state_d = cbu_pkg::S_TRAVEL_MUL;
					end
				endcase
			end
			cbu_pkg::S_TRAVEL_MUL: begin
				cmd.uop = cbu_pkg::UOP_TRAVEL_MUL;
				state_d = cbu_pkg::S_TRAVEL_ADD;
			end
			cbu_pkg::S_TRAVEL_ADD: begin
				cmd.uop = cbu_pkg::UOP_TRAVEL_ADD;
				if (k_q == 2'd2) begin
					k_d     = '0;
					state_d = cbu_pkg::S_FINISH;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = cbu_pkg::S_TRAVEL_MUL;
				end
			end
			cbu_pkg::S_TRIG_INIT: begin
				cmd.uop = cbu_pkg::UOP_TRIG_INIT;
				i_d     = '0;
				state_d = cbu_pkg::S_TRIG_STEP;
			end
			cbu_pkg::S_TRIG_STEP: begin
				cmd.uop = cbu_pkg::UOP_TRIG_STEP;
				if (i_q == SW'(TRIG_ITERATIONS - 1)) begin
					i_d     = '0;
					state_d = cbu_pkg::S_MIX_P;
				end else begin
					i_d = i_q + SW'(1);
				end
			end
			cbu_pkg::S_MIX_P: begin
				cmd.uop = cbu_pkg::UOP_MIX_P;
				state_d = cbu_pkg::S_MIX_Q;
			end
			cbu_pkg::S_MIX_Q: begin
				cmd.uop = cbu_pkg::UOP_MIX_Q;
				state_d = cbu_pkg::S_MIX_W;
			end
			cbu_pkg::S_MIX_W: begin
				cmd.uop = cbu_pkg::UOP_MIX_W;
				if (k_q == 2'd2) begin
					k_d     = '0;
					state_d = cbu_pkg::S_SQ;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = cbu_pkg::S_MIX_P;
				end
			end
			cbu_pkg::S_SQ: begin
				cmd.uop = cbu_pkg::UOP_SQ;
				state_d = cbu_pkg::S_SQ_ACC;
			end
			cbu_pkg::S_SQ_ACC: begin
				cmd.uop = cbu_pkg::UOP_SQ_ACC;
				if (k_q == 2'd2) begin
					k_d     = '0;
					state_d = cbu_pkg::S_SQRT_INIT;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = cbu_pkg::S_SQ;
				end
			end
			cbu_pkg::S_SQRT_INIT: begin
				cmd.uop = cbu_pkg::UOP_SQRT_INIT;
				i_d     = '0;
				state_d = cbu_pkg::S_SQRT_STEP;
			end
			cbu_pkg::S_SQRT_STEP: begin
				cmd.uop = cbu_pkg::UOP_SQRT_STEP;
				if (i_q == SW'(cbu_pkg::SQRT_STEPS - 1)) begin
					i_d     = '0;
					state_d = cbu_pkg::S_NORM_CHECK;
				end else begin
					i_d = i_q + SW'(1);
				end
			end
			cbu_pkg::S_NORM_CHECK: begin
				k_d = '0;
				// zero length keeps the old vector
				if (stat.len_zero) begin
					state_d = cbu_pkg::S_CROSS_A;
				end else begin
					state_d = cbu_pkg::S_DIV_INIT;
				end
			end
			cbu_pkg::S_DIV_INIT: begin
				cmd.uop = cbu_pkg::UOP_DIV_INIT;
				i_d     = '0;
				state_d = cbu_pkg::S_DIV_STEP;
			end
			cbu_pkg::S_DIV_STEP: begin
				cmd.uop = cbu_pkg::UOP_DIV_STEP;
				if (i_q == SW'(DIR_WIDTH - 1)) begin
					i_d     = '0;
					state_d = cbu_pkg::S_DIV_WRITE;
				end else begin
					i_d = i_q + SW'(1);
				end
			end
			cbu_pkg::S_DIV_WRITE: begin
				cmd.uop = cbu_pkg::UOP_DIV_WRITE;
				if (k_q == 2'd2) begin
					k_d     = '0;
					state_d = cbu_pkg::S_CROSS_A;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = cbu_pkg::S_DIV_INIT;
				end
			end
			cbu_pkg::S_CROSS_A: begin
				cmd.uop = cbu_pkg::UOP_CROSS_A;
				state_d = cbu_pkg::S_CROSS_B;
			end
			cbu_pkg::S_CROSS_B: begin
				cmd.uop = cbu_pkg::UOP_CROSS_B;
				state_d = cbu_pkg::S_CROSS_W;
			end
			cbu_pkg::S_CROSS_W: begin
				cmd.uop = cbu_pkg::UOP_CROSS_W;
				if (k_q == 2'd2) begin
					k_d     = '0;
					state_d = cbu_pkg::S_FINISH;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = cbu_pkg::S_CROSS_A;
				end
			end
			cbu_pkg::S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.uop     = cbu_pkg::UOP_CAPTURE;
					out_valid_d = 1'b1;
					state_d     = cbu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cbu_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/cbu_datapath.sv =====
// cbu_datapath: camera state, shared multiplier, cordic, square root and divider
// depends on cbu_pkg; driven by cbu_controller

module cbu_datapath #(
	parameter int DIR_WIDTH = cbu_pkg::DIR_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cbu_pkg::dp_cmd_t   cmd,
	output cbu_pkg::dp_stat_t  stat,
	input  cbu_pkg::cam_cmd_t  in_data,
	output cbu_pkg::cam_res_t  out_data
);

	localparam int DW   = DIR_WIDTH;
	localparam int F    = DIR_WIDTH - 2;
	localparam int MW   = cbu_pkg::MUL_W;
	localparam int PW   = 2 * MW;
	localparam int SH_R = (DIR_WIDTH >= 16) ? DIR_WIDTH - 16 : 0;
	localparam int SH_L = (DIR_WIDTH < 16) ? 16 - DIR_WIDTH : 0;

	typedef logic signed [DW-1:0] dir_t;

	localparam dir_t ONE     = dir_t'(DW'(1) << F);
	localparam dir_t NEG_ONE = -ONE;
	localparam logic signed [PW-1:0] DIR_HI   = PW'(2 ** (DW - 1) - 1);
	localparam logic signed [PW-1:0] DIR_LO   = -DIR_HI - PW'(1);
	localparam logic signed [PW-1:0] POS_HI   = PW'(64'h7FFF_FFFF);
	localparam logic signed [PW-1:0] POS_LO   = -POS_HI - PW'(1);
	localparam logic signed [PW-1:0] HALF_MIX = PW'(1) << (DW - 2);
	localparam logic signed [PW-1:0] HALF_F   = PW'(1) << (F - 1);
	localparam logic [DW-1:0] QMAX = DW'(1) << (DW - 1);
	localparam logic signed [DW:0] NORM_HI = (DW + 1)'(2 ** (DW - 1) - 1);
	localparam logic signed [16:0] DEG90  = 17'(cbu_pkg::DEG90_Q8);
	localparam logic signed [16:0] DEG180 = 17'(cbu_pkg::DEG180_Q8);
	localparam logic [1:0] TGT_VIEW  = 2'd0;
	localparam logic [1:0] TGT_UP    = 2'd1;
	localparam logic [1:0] TGT_RIGHT = 2'd2;

	logic [2:0]         opcode_q;
	logic signed [15:0] angle_q;
	logic signed [31:0] dist_q, mvx_q, mvy_q, mvz_q;
	logic signed [31:0] pos_q [3];
	dir_t               view_q [3];
	dir_t               up_q [3];
	dir_t               right_q [3];
	logic signed [MW-1:0] x_q, y_q;
	logic signed [39:0]   z_q;
	logic                 neg_q;
	logic signed [PW-1:0] prod_s1, acc_q;
	logic signed [MW-1:0] w_q [3];
	logic [63:0]          sum_q, sn_q, sr_q, sbit_q;
	logic [32:0]          rem_q;
	logic [DW-1:0]        dq_q;
	cbu_pkg::cam_res_t    res_q;

	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		logic signed [31:0] r;
		if (v > POS_HI) r = 32'sh7FFF_FFFF;
		else if (v < POS_LO) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic dir_t sat_dir(input logic signed [PW-1:0] v);
		dir_t r;
		if (v > DIR_HI) r = DIR_HI[DW-1:0];
		else if (v < DIR_LO) r = DIR_LO[DW-1:0];
		else r = v[DW-1:0];
		return r;
	endfunction

	function automatic logic signed [15:0] dir_out(input dir_t v);
		logic signed [39:0] e;
		e = 40'(v);
		e = (e >>> SH_R) <<< SH_L;
		return e[15:0];
	endfunction

	// operand selection
	logic [1:0] idx1, idx2;
	dir_t vp [3];
	dir_t vq [3];
	dir_t ca [3];
	dir_t cb [3];
	dir_t vt [3];
	logic signed [MW-1:0] c_val, s_val;
	logic signed [MW-1:0] wmag [3];
	logic signed [MW-1:0] ma, mb;

	assign idx1 = (cmd.k == 2'd2) ? 2'd0 : cmd.k + 2'd1;
	assign idx2 = (cmd.k == 2'd0) ? 2'd2 : cmd.k - 2'd1;

	always_comb begin
		case (opcode_q)
			cbu_pkg::OP_ROT_Y: begin
				vp = view_q;  vq = right_q; ca = view_q;  cb = up_q;
			end
			cbu_pkg::OP_ROT_Z: begin
				vp = right_q; vq = up_q;    ca = right_q; cb = view_q;
			end
			default: begin
				vp = view_q;  vq = up_q;    ca = right_q; cb = view_q;
			end
		endcase
		case (opcode_q)
			cbu_pkg::OP_FORWARD: vt = view_q;
			cbu_pkg::OP_STRAFE:  vt = right_q;
			default:             vt = up_q;
		endcase
	end

	assign c_val = neg_q ? -x_q : x_q;
	assign s_val = (opcode_q == cbu_pkg::OP_ROT_Y) ? -y_q : y_q;

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			wmag[n] = (w_q[n] < 0) ? -w_q[n] : w_q[n];
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.uop)
			cbu_pkg::UOP_TRAVEL_MUL: begin
				ma = MW'(dist_q);     mb = MW'(vt[cmd.k]);
			end
			cbu_pkg::UOP_MIX_P: begin
				ma = c_val;           mb = MW'(vp[cmd.k]);
			end
			cbu_pkg::UOP_MIX_Q: begin
				ma = s_val;           mb = MW'(vq[cmd.k]);
			end
			cbu_pkg::UOP_SQ: begin
				ma = wmag[cmd.k];     mb = wmag[cmd.k];
			end
			cbu_pkg::UOP_CROSS_A: begin
				ma = MW'(ca[idx1]);   mb = MW'(cb[idx2]);
			end
			cbu_pkg::UOP_CROSS_B: begin
				ma = MW'(ca[idx2]);   mb = MW'(cb[idx1]);
			end
			default: ;
		endcase
	end

	// arithmetic on the registered product and the work registers
	logic signed [PW-1:0] mix_sum, mix_rnd, cr_sum, cr_rnd, tr_rnd, tr_pos;
	logic signed [PW-1:0] mv_x, mv_y, mv_z;
	logic signed [16:0]   fa;
	logic signed [MW-1:0] sh_x, sh_y;
	logic signed [39:0]   atan_v;
	logic [63:0]          sq_t;
	logic [31:0]          len;
	logic [63:0]          div_n;
	logic [33:0]          div_t;
	logic                 div_ge;
	logic [DW-1:0]        qc;
	logic signed [DW:0]   qs;
	dir_t                 norm_val;

	always_comb begin
		mix_sum = acc_q + prod_s1;
		mix_rnd = (mix_sum + HALF_MIX) >>> (DW - 1);
		cr_sum  = acc_q - prod_s1;
		cr_rnd  = (cr_sum + HALF_F) >>> F;
		tr_rnd  = (prod_s1 + HALF_F) >>> F;
		if (opcode_q == cbu_pkg::OP_FORWARD) tr_rnd = -tr_rnd;
		tr_pos  = PW'(pos_q[cmd.k]) + tr_rnd;
		mv_x    = PW'(pos_q[0]) + PW'(mvx_q);
		mv_y    = PW'(pos_q[1]) + PW'(mvy_q);
		mv_z    = PW'(pos_q[2]) + PW'(mvz_q);
		fa      = 17'(angle_q);
		if (fa > DEG90) fa = DEG180 - fa;
		else if (fa < -DEG90) fa = -DEG180 - fa;
		sh_x    = x_q >>> cmd.step;
		sh_y    = y_q >>> cmd.step;
		atan_v  = cbu_pkg::atan_q24(cmd.step[4:0]);
		sq_t    = sr_q + sbit_q;
		len     = sr_q[31:0];
		div_n   = (64'(unsigned'(wmag[cmd.k])) << F) + 64'(len >> 1);
		div_t   = {rem_q, dq_q[DW-1]};
		div_ge  = div_t >= {2'b00, len};
		qc      = (dq_q > QMAX) ? QMAX : dq_q;
		qs      = (w_q[cmd.k] < 0) ? -signed'({1'b0, qc}) : signed'({1'b0, qc});
		norm_val = (qs > NORM_HI) ? NORM_HI[DW-1:0] : qs[DW-1:0];
	end

	logic       dir_we;
	logic [1:0] dir_tgt;
	dir_t       dir_val;

	always_comb begin
		dir_we  = 1'b0;
		dir_tgt = TGT_VIEW;
		dir_val = norm_val;
		case (cmd.uop)
			cbu_pkg::UOP_DIV_WRITE: begin
				dir_we  = 1'b1;
				dir_tgt = (opcode_q == cbu_pkg::OP_ROT_Z) ? TGT_RIGHT : TGT_VIEW;
			end
			cbu_pkg::UOP_CROSS_W: begin
				dir_we  = 1'b1;
				dir_tgt = (opcode_q == cbu_pkg::OP_ROT_Y) ? TGT_RIGHT : TGT_UP;
				dir_val = sat_dir(cr_rnd);
			end
			default: ;
		endcase
	end

	// camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '{32'sd0, 32'sd0, 32'(cbu_pkg::POS_Z_RESET)};
			view_q  <= '{dir_t'(0), dir_t'(0), NEG_ONE};
			up_q    <= '{dir_t'(0), ONE, dir_t'(0)};
			right_q <= '{ONE, dir_t'(0), dir_t'(0)};
		end else begin
			case (cmd.uop)
				cbu_pkg::UOP_RESET: begin
					pos_q   <= '{32'sd0, 32'sd0, 32'(cbu_pkg::POS_Z_RESET)};
					view_q  <= '{dir_t'(0), dir_t'(0), NEG_ONE};
					up_q    <= '{dir_t'(0), ONE, dir_t'(0)};
					right_q <= '{ONE, dir_t'(0), dir_t'(0)};
				end
				cbu_pkg::UOP_MOVE: begin
					pos_q <= '{sat32(mv_x), sat32(mv_y), sat32(mv_z)};
				end
				cbu_pkg::UOP_TRAVEL_ADD: begin
					pos_q[cmd.k] <= sat32(tr_pos);
				end
				default: ;
			endcase
			if (dir_we) begin
				case (dir_tgt)
					TGT_VIEW:  view_q[cmd.k]  <= dir_val;
					TGT_UP:    up_q[cmd.k]    <= dir_val;
					default:   right_q[cmd.k] <= dir_val;
				endcase
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		case (cmd.uop)
			cbu_pkg::UOP_LOAD: begin
				opcode_q <= in_data.opcode;
				angle_q  <= in_data.rotate_angle;
				dist_q   <= in_data.travel_distance;
				mvx_q    <= in_data.move_x;
				mvy_q    <= in_data.move_y;
				mvz_q    <= in_data.move_z;
			end
			cbu_pkg::UOP_TRIG_INIT: begin
				x_q   <= MW'(cbu_pkg::CORDIC_GAIN_Q30);
				y_q   <= '0;
				z_q   <= 40'(fa) <<< 16;
				neg_q <= (fa != 17'(angle_q));
				sum_q <= '0;
			end
			cbu_pkg::UOP_TRIG_STEP: begin
				if (z_q >= 0) begin
					x_q <= x_q - sh_y;
					y_q <= y_q + sh_x;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + sh_y;
					y_q <= y_q - sh_x;
					z_q <= z_q + atan_v;
				end
			end
			cbu_pkg::UOP_MIX_Q, cbu_pkg::UOP_CROSS_B: begin
				acc_q <= prod_s1;
			end
			cbu_pkg::UOP_MIX_W: begin
				w_q[cmd.k] <= MW'(mix_rnd);
			end
			cbu_pkg::UOP_SQ_ACC: begin
				sum_q <= sum_q + prod_s1[63:0];
			end
			cbu_pkg::UOP_SQRT_INIT: begin
				sn_q   <= sum_q;
				sr_q   <= '0;
				sbit_q <= 64'h4000_0000_0000_0000;
			end
			cbu_pkg::UOP_SQRT_STEP: begin
				if (sn_q >= sq_t) begin
					sn_q <= sn_q - sq_t;
					sr_q <= (sr_q >> 1) + sbit_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			cbu_pkg::UOP_DIV_INIT: begin
				rem_q <= 33'(div_n >> DW);
				dq_q  <= div_n[DW-1:0];
			end
			cbu_pkg::UOP_DIV_STEP: begin
				rem_q <= div_ge ? 33'(div_t - {2'b00, len}) : div_t[32:0];
				dq_q  <= {dq_q[DW-2:0], div_ge};
			end
			cbu_pkg::UOP_CAPTURE: begin
				res_q.pos_x   <= pos_q[0];
				res_q.pos_y   <= pos_q[1];
				res_q.pos_z   <= pos_q[2];
				res_q.view_x  <= dir_out(view_q[0]);
				res_q.view_y  <= dir_out(view_q[1]);
				res_q.view_z  <= dir_out(view_q[2]);
				res_q.up_x    <= dir_out(up_q[0]);
				res_q.up_y    <= dir_out(up_q[1]);
				res_q.up_z    <= dir_out(up_q[2]);
				res_q.right_x <= dir_out(right_q[0]);
				res_q.right_y <= dir_out(right_q[1]);
				res_q.right_z <= dir_out(right_q[2]);
			end
			default: ;
		endcase
	end

	assign stat.opcode   = opcode_q;
	assign stat.len_zero = (sr_q == 64'd0);
	assign out_data      = res_q;

endmodule

// ===== bench/camera_basis_update_tb.sv =====
// camera_basis_update_tb: self-checking bench for the camera position and basis unit
// drives command beats, predicts each result beat and compares it field by field
// depends on cbu_pkg, cbu_stream_if and camera_basis_update
`timescale 1ns / 100ps

module camera_basis_update_tb;

	typedef longint vec_t[3];

	class camera_tracker;
		vec_t     pos, vw, upv, rt;
		cbu_pkg::cam_res_t pending_q[$];
		int       errors;
		int       results_seen;
		int       rotations;
		longint   atan_tbl[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
			30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
			117342, 58671, 29335};

		function new();
			home();
			errors = 0;
			results_seen = 0;
			rotations = 0;
		endfunction

		function void home();
			pos = '{0, 0, cbu_pkg::POS_Z_RESET};
			vw  = '{0, 0, -16384};
			upv = '{0, 16384, 0};
			rt  = '{16384, 0, 0};
		endfunction

		function longint clamp(longint v, int w);
			longint hi, lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			return v > hi ? hi : (v < lo ? lo : v);
		endfunction

		function longint round_shift(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function void sin_cos(longint a, output longint c, output longint s);
			longint x, y, z, nx;
			bit     flip;
			flip = 0;
			if (a > cbu_pkg::DEG90_Q8) begin
				a = cbu_pkg::DEG180_Q8 - a;
				flip = 1;
			end else if (a < -cbu_pkg::DEG90_Q8) begin
				a = -cbu_pkg::DEG180_Q8 - a;
				flip = 1;
			end
			x = cbu_pkg::CORDIC_GAIN_Q30;
			y = 0;
			z = a * 65536;
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y  = y + (x >>> i);
					z  = z - atan_tbl[i];
				end else begin
					nx = x + (y >>> i);
					y  = y - (x >>> i);
					z  = z + atan_tbl[i];
				end
				x = nx;
			end
			c = flip ? -x : x;
			s = y;
		endfunction

		function bit [63:0] root_floor(bit [63:0] n);
			bit [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n)
				b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function void blend_unit(inout vec_t dst, input vec_t p, input vec_t q,
				input longint c, input longint s);
			longint    w[3];
			bit [63:0] sum, len, mag, quo;
			sum = 0;
			for (int k = 0; k < 3; k++) begin
				w[k] = round_shift(c * p[k] + s * q[k], 15);
				mag = w[k] < 0 ? -w[k] : w[k];
				sum += mag * mag;
			end
			len = root_floor(sum);
			if (len == 0)
				return;
			for (int k = 0; k < 3; k++) begin
				mag = w[k] < 0 ? -w[k] : w[k];
				quo = ((mag << 14) + len / 2) / len;
				if (quo > 64'd32768)
					quo = 64'd32768;
				dst[k] = clamp(w[k] < 0 ? -longint'(quo) : longint'(quo), 16);
			end
		endfunction

		function void cross_prod(output vec_t dst, input vec_t a, input vec_t b);
			dst[0] = clamp(round_shift(a[1] * b[2] - a[2] * b[1], 14), 16);
			dst[1] = clamp(round_shift(a[2] * b[0] - a[0] * b[2], 14), 16);
			dst[2] = clamp(round_shift(a[0] * b[1] - a[1] * b[0], 14), 16);
		endfunction

		function void glide(vec_t d, longint span, bit negate);
			longint delta;
			for (int k = 0; k < 3; k++) begin
				delta = round_shift(span * d[k], 14);
				pos[k] = clamp(pos[k] + (negate ? -delta : delta), 32);
			end
		endfunction

		function void note_command(cbu_pkg::cam_cmd_t cmd);
			longint   c, s;
			cbu_pkg::cam_res_t r;
			if (cmd.opcode inside {cbu_pkg::OP_ROT_X, cbu_pkg::OP_ROT_Y,
					cbu_pkg::OP_ROT_Z}) begin
				sin_cos(longint'(cmd.rotate_angle), c, s);
				rotations++;
			end
			case (cmd.opcode)
				cbu_pkg::OP_RESET: home();
				cbu_pkg::OP_MOVE: begin
					pos[0] = clamp(pos[0] + longint'(cmd.move_x), 32);
					pos[1] = clamp(pos[1] + longint'(cmd.move_y), 32);
					pos[2] = clamp(pos[2] + longint'(cmd.move_z), 32);
				end
				cbu_pkg::OP_ROT_X: begin
					blend_unit(vw, vw, upv, c, s);
					cross_prod(upv, rt, vw);
				end
				cbu_pkg::OP_ROT_Y: begin
					blend_unit(vw, vw, rt, c, -s);
					cross_prod(rt, vw, upv);
				end
				cbu_pkg::OP_ROT_Z: begin
					blend_unit(rt, rt, upv, c, s);
					cross_prod(upv, rt, vw);
				end
				cbu_pkg::OP_FORWARD: glide(vw, longint'(cmd.travel_distance), 1);
				cbu_pkg::OP_STRAFE: glide(rt, longint'(cmd.travel_distance), 0);
				default: glide(upv, longint'(cmd.travel_distance), 0);
			endcase
			r.pos_x = pos[0][31:0];
			r.pos_y = pos[1][31:0];
			r.pos_z = pos[2][31:0];
			r.view_x = vw[0][15:0];
			r.view_y = vw[1][15:0];
			r.view_z = vw[2][15:0];
			r.up_x = upv[0][15:0];
			r.up_y = upv[1][15:0];
			r.up_z = upv[2][15:0];
			r.right_x = rt[0][15:0];
			r.right_y = rt[1][15:0];
			r.right_z = rt[2][15:0];
			pending_q.push_back(r);
		endfunction

		function void compare(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v,
					act_v);
			end
		endfunction

		function void check_result(cbu_pkg::cam_res_t act);
			cbu_pkg::cam_res_t e;
			results_seen++;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, got %h", $time, act);
				return;
			end
			e = pending_q.pop_front();
			compare("pos_x", e.pos_x, act.pos_x);
			compare("pos_y", e.pos_y, act.pos_y);
			compare("pos_z", e.pos_z, act.pos_z);
			compare("view_x", e.view_x, act.view_x);
			compare("view_y", e.view_y, act.view_y);
			compare("view_z", e.view_z, act.view_z);
			compare("up_x", e.up_x, act.up_x);
			compare("up_y", e.up_y, act.up_y);
			compare("up_z", e.up_z, act.up_z);
			compare("right_x", e.right_x, act.right_x);
			compare("right_y", e.right_y, act.right_y);
			compare("right_z", e.right_z, act.right_z);
		endfunction
	endclass

	localparam longint CYCLE_LIMIT = 3000000;
	localparam int     HOLD_CYCLES = 1500;

	logic clk = 0;
	logic arst_n = 0;

	cbu_stream_if #(.payload_t(cbu_pkg::cam_cmd_t)) cmd_if ();
	cbu_stream_if #(.payload_t(cbu_pkg::cam_res_t)) res_if ();

	camera_basis_update dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	camera_tracker tracker = new();
	int     send_idle = 37;
	int     recv_idle = 78;
	int     hold_req = 0;
	int     hold_seen = 0;
	int     hold_left = 0;
	int     commands_sent = 0;
	longint cycles = 0;

	initial begin
		cmd_if.valid = 0;
		cmd_if.data = '0;
		res_if.ready = 0;
	end

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: check accepted beats, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready)
				tracker.check_result(res_if.data);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic send_cmd(cbu_pkg::cam_cmd_t c);
		while ($urandom_range(99) < send_idle) begin
			cmd_if.valid <= 0;
			@(posedge clk);
		end
		cmd_if.valid <= 1;
		cmd_if.data <= c;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		tracker.note_command(c);
		commands_sent++;
	endtask

	task automatic drain_results();
		cmd_if.valid <= 0;
		while (tracker.pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h000fffff);
			2: return -$urandom_range(32'h000fffff);
			default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	function automatic cbu_pkg::cam_cmd_t fill_cmd(logic [2:0] op, logic [15:0] ang,
			logic [31:0] span, logic [31:0] mx, logic [31:0] my, logic [31:0] mz);
		cbu_pkg::cam_cmd_t c;
		c.opcode = op;
		c.rotate_angle = ang;
		c.travel_distance = span;
		c.move_x = mx;
		c.move_y = my;
		c.move_z = mz;
		return c;
	endfunction

	function automatic cbu_pkg::cam_cmd_t random_cmd();
		logic [2:0]  op;
		logic [15:0] ang;
		op = ($urandom_range(99) < 4) ? cbu_pkg::OP_RESET : 3'($urandom_range(7, 1));
		case ($urandom_range(2))
			0: ang = 16'($urandom);
			1: ang = 16'($urandom_range(16'h1800) - 16'h0c00);
			default: ang = 16'($urandom_range(16'hb400) - 16'h5a00);
		endcase
		return fill_cmd(op, ang, pick32(), pick32(), pick32(), pick32());
	endfunction

	task automatic directed_cmds();
		logic [15:0] angles[8] = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd32767,
			-16'sd32768, 16'sd11520, 16'sd1, -16'sd1};
		send_cmd(fill_cmd(cbu_pkg::OP_RESET, 16'($urandom), $urandom, $urandom, $urandom,
			$urandom));
		send_cmd(fill_cmd(cbu_pkg::OP_MOVE, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_cmd(fill_cmd(cbu_pkg::OP_MOVE, 0, 0, 32'h7fffffff, 32'h80000000, 32'h00000001));
		send_cmd(fill_cmd(cbu_pkg::OP_MOVE, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000));
		send_cmd(fill_cmd(cbu_pkg::OP_FORWARD, 0, 32'h7fffffff, 0, 0, 0));
		send_cmd(fill_cmd(cbu_pkg::OP_STRAFE, 0, 32'h80000000, 0, 0, 0));
		send_cmd(fill_cmd(cbu_pkg::OP_UPWARD, 0, 32'h7fffffff, 0, 0, 0));
		send_cmd(fill_cmd(cbu_pkg::OP_RESET, 0, 0, 0, 0, 0));
		for (int i = 0; i < 8; i++)
			send_cmd(fill_cmd(cbu_pkg::OP_ROT_X + 3'(i % 3), angles[i], $urandom, 0, 0, 0));
		send_cmd(fill_cmd(cbu_pkg::OP_ROT_Y, angles[3], 0, 0, 0, 0));
		send_cmd(fill_cmd(cbu_pkg::OP_ROT_Z, angles[4], 0, 0, 0, 0));
		send_cmd(fill_cmd(cbu_pkg::OP_FORWARD, 0, 32'h00010000, 0, 0, 0));
		send_cmd(fill_cmd(cbu_pkg::OP_STRAFE, 0, 32'hffff0000, 0, 0, 0));
		send_cmd(fill_cmd(cbu_pkg::OP_UPWARD, 0, 32'h00008000, 0, 0, 0));
		send_cmd(fill_cmd(cbu_pkg::OP_RESET, 0, 0, 0, 0, 0));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_cmds();
		drain_results();
		// stall the result side while commands keep coming
		hold_req++;
		for (int i = 0; i < 20; i++)
			send_cmd(random_cmd());
		drain_results();
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 37 : (phase == 1) ? 78 : 0;
			recv_idle = (phase == 0) ? 78 : (phase == 1) ? 37 : 0;
			for (int i = 0; i < 570; i++)
				send_cmd(random_cmd());
		end
		drain_results();
		repeat (300) @(posedge clk);
		$display("commands sent %0d, rotations %0d, result beats checked %0d",
			commands_sent, tracker.rotations, tracker.results_seen);
		$display("covered resets, moves, saturation, travel and rotations under stalls");
		if (tracker.errors == 0 && tracker.pending_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
